// ===== hdl/fwqi_pkg.sv =====
// ----------------------------------------------------------------------------
// fwqi_pkg: shared types for the indexed wait queue
// Operation and status codes carried on the stream buses, and the
// sequencer states of the top level.
// ----------------------------------------------------------------------------
package fwqi_pkg;

   // Operation requested by one input transfer (travels in req_tuser)
   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_PEEK   = 2'd2,
      FUNC_REMOVE = 2'd3
   } func_type;

   // Outcome reported with each result (travels in rsp_tuser)
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_SHIFT,
      S_DONE
   } state_type;

   // Fixed field widths of the payload
   localparam int IDENT_W = 31;
   localparam int GSIZE_W = 8;
   localparam int POS_W   = 8;
   localparam int LEN_W   = 5;

endpackage

// ===== hdl/fwqi_ram.sv =====
// ----------------------------------------------------------------------------
// fwqi_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fwqi_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fifo_wait_queue_indexed.sv =====
// ----------------------------------------------------------------------------
// fifo_wait_queue_indexed: bounded FIFO of waiting entries with indexed access
//
// Input stream (req_): one transfer asks for push, pop, peek at a position
// or remove at a position. Result stream (rsp_): exactly one transfer per
// request, carrying a status, the entry read (zero on push or error) and the
// number of entries held afterwards.
// Entries sit in a circular buffer in a small RAM with a head pointer, so a
// pop only moves the head. Remove closes the gap by moving every later entry
// one place towards the head, one entry per cycle through the RAM port.
// Each request passes the sequencer states idle, decode, fetch (pop, peek
// and remove), shift (remove with later entries) and done, then enters the
// output register; push and any error go from decode to done. The RAM's
// single read/write port pair sets the one-entry-per-cycle shift. One request
// is in progress at a time; req_tready is high only while the sequencer is
// idle, so a new request is taken only after the last one has left done.
// Reset empties the queue at once (the RAM itself is not cleared). A result
// waits in the output register while rsp_tready is low; the next request may
// be taken meanwhile, but its result is held back until the register frees.
// ----------------------------------------------------------------------------
module fifo_wait_queue_indexed #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // ident[30:0], group_size[38:31], position[46:39]
   input  logic [1:0]  req_tuser,  // func[1:0]
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_ident[30:0], out_group_size[38:31], length[43:39]
   output logic [1:0]  rsp_tuser   // status[1:0]
);
   import fwqi_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int EW = IDENT_W + GSIZE_W;

   // Physical RAM address of logical position b behind head a
   function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
      logic [AW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // Sequencer and queue state
   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        k_ff, k_in;

   // Latched request
   func_type             op_func_ff, op_func_in;
   logic [IDENT_W-1:0]   op_ident_ff, op_ident_in;
   logic [GSIZE_W-1:0]   op_gsize_ff, op_gsize_in;
   logic [POS_W-1:0]     op_pos_ff, op_pos_in;

   // Pending result
   status_type           res_status_ff, res_status_in;
   logic [IDENT_W-1:0]   res_ident_ff, res_ident_in;
   logic [GSIZE_W-1:0]   res_gsize_ff, res_gsize_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;
   logic [47:0]          rsp_data_ff, rsp_data_in;

   // RAM port signals
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [EW-1:0]        ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [EW-1:0]        ram_rd_data;

   logic                 req_fire;

   fwqi_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      op_func_ff    <= op_func_in;
      op_ident_ff   <= op_ident_in;
      op_gsize_ff   <= op_gsize_in;
      op_pos_ff     <= op_pos_in;
      res_status_ff <= res_status_in;
      res_ident_ff  <= res_ident_in;
      res_gsize_ff  <= res_gsize_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      op_func_in    = op_func_ff;
      op_ident_in   = op_ident_ff;
      op_gsize_in   = op_gsize_ff;
      op_pos_in     = op_pos_ff;
      res_status_in = res_status_ff;
      res_ident_in  = res_ident_ff;
      res_gsize_in  = res_gsize_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = add_mod(head_ff, k_ff[AW-1:0]);
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = add_mod(head_ff, AW'(k_ff + CW'(2)));

      unique case (state_ff)
         S_IDLE: begin
            // Latch the request
            if (req_fire) begin
               op_func_in  = func_type'(req_tuser);
               op_ident_in = req_tdata[IDENT_W-1:0];
               op_gsize_in = req_tdata[IDENT_W +: GSIZE_W];
               op_pos_in   = req_tdata[IDENT_W+GSIZE_W +: POS_W];
               state_in    = S_DECODE;
            end
         end

         S_DECODE: begin
            // Check bounds; push writes here, the others start a read
            res_status_in = STAT_OK;
            res_ident_in  = '0;
            res_gsize_in  = '0;
            ram_wr_addr   = add_mod(head_ff, count_ff[AW-1:0]);
            ram_wr_data   = {op_gsize_ff, op_ident_ff};
            ram_rd_addr   = (op_func_ff == FUNC_POP) ? head_ff
                          : add_mod(head_ff, AW'(op_pos_ff));
            k_in          = CW'(op_pos_ff);
            unique case (op_func_ff)
               FUNC_PUSH: begin
                  state_in = S_DONE;
                  if (count_ff >= CW'(DEPTH)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end
               end
               FUNC_POP: begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
               default: begin
                  if (PW'(op_pos_ff) >= PW'(count_ff)) begin
                     res_status_in = STAT_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
            endcase
         end

         S_FETCH: begin
            // Entry is on the RAM output now
            res_ident_in = ram_rd_data[IDENT_W-1:0];
            res_gsize_in = ram_rd_data[IDENT_W +: GSIZE_W];
            ram_rd_addr  = add_mod(head_ff, AW'(k_ff + CW'(1)));
            state_in     = S_DONE;
            unique case (op_func_ff)
               FUNC_POP: begin
                  head_in  = add_mod(head_ff, AW'(1));
                  count_in = count_ff - CW'(1);
               end
               FUNC_REMOVE: begin
                  if (k_ff + CW'(1) < count_ff) begin
                     state_in = S_SHIFT;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
               default: begin
               end
            endcase
         end

         S_SHIFT: begin
            // Move entry k+1 into slot k, fetch k+2 for the next cycle
            ram_wr_en = 1'b1;
            if (k_ff + CW'(2) < count_ff) begin
               k_in = k_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {4'b0000, LEN_W'(count_ff), res_gsize_ff, res_ident_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // Occupancy never exceeds the queue size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue occupancy beyond DEPTH");

   // Occupancy moves by at most one entry at a time
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CW'(1) || count_ff + CW'(1) == $past(count_ff)))
      else $error("queue occupancy jumped");

   // Gap closing only happens for a remove request
   a_shift_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (op_func_ff == FUNC_REMOVE))
      else $error("shift without remove request");

   // A pending result is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result overwritten");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for fifo_wait_queue_indexed
// Drives push, pop, peek and remove requests on the req_ stream and checks
// every rsp_ transfer field by field against a behavioural copy of the
// queue kept in the bench. A short directed run covers empty, full and
// out-of-range cases, then random segments bias towards filling, draining
// or mixed traffic, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
   import fwqi_pkg::*;

   localparam int QDEPTH       = 16;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int CALM_TAIL    = 150;

   typedef struct {
      func_type             func;
      logic [IDENT_W-1:0]   ident;
      logic [GSIZE_W-1:0]   gsize;
      logic [POS_W-1:0]     pos;
      bit                   hold;   // pause until every result is back
      bit                   quiet;  // no gaps on either side
   } queue_req_type;

   typedef struct {
      status_type           status;
      logic [IDENT_W-1:0]   ident;
      logic [GSIZE_W-1:0]   gsize;
      logic [LEN_W-1:0]     length;
   } queue_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;  // ident[30:0], group_size[38:31], position[46:39]
   logic [1:0]  req_tuser  = FUNC_PUSH;  // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;  // out_ident[30:0], out_group_size[38:31], length[43:39]
   logic [1:0]  rsp_tuser;  // status[1:0]

   queue_req_type req_backlog[$];
   queue_rsp_type rsp_expected[$];

   // Bench copy of the queue contents
   logic [IDENT_W-1:0] line_ident[QDEPTH];
   logic [GSIZE_W-1:0] line_gsize[QDEPTH];
   int                 line_count = 0;

   // Occupancy as seen by the stimulus generator
   int gen_len = 0;

   queue_req_type drv_item;
   bit         req_taken  = 1'b0;
   bit         quiet_now  = 1'b0;
   int         req_gap    = 0;
   int         rsp_stall  = 0;
   int         mismatches = 0;
   int         cycle_count = 0;

   fifo_wait_queue_indexed #(.DEPTH(QDEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Apply one request to the bench queue and return the result it gives
   function automatic queue_rsp_type apply_queue_op(queue_req_type it);
      queue_rsp_type r;
      int         at;
      bit         hit;
      bit         drop;
      r.status = STAT_OK;
      r.ident  = '0;
      r.gsize  = '0;
      at   = 0;
      hit  = 1'b0;
      drop = 1'b0;
      case (it.func)
         FUNC_PUSH: begin
            if (line_count >= QDEPTH) begin
               r.status = STAT_FULL;
            end else begin
               line_ident[line_count] = it.ident;
               line_gsize[line_count] = it.gsize;
               line_count++;
            end
         end
         FUNC_POP: begin
            if (line_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               hit  = 1'b1;
               drop = 1'b1;
            end
         end
         default: begin
            if (int'(it.pos) >= line_count) begin
               r.status = STAT_RANGE;
            end else begin
               at   = int'(it.pos);
               hit  = 1'b1;
               drop = (it.func == FUNC_REMOVE);
            end
         end
      endcase
      if (hit) begin
         r.ident = line_ident[at];
         r.gsize = line_gsize[at];
      end
      // close the gap, later entries move one place towards the head
      if (drop) begin
         for (int k = at; k + 1 < line_count; k++) begin
            line_ident[k] = line_ident[k + 1];
            line_gsize[k] = line_gsize[k + 1];
         end
         line_count--;
      end
      r.length = LEN_W'(line_count);
      return r;
   endfunction

   // Queue one request and track the occupancy it leaves behind
   function automatic void add_req(func_type f, logic [IDENT_W-1:0] id,
                                   logic [GSIZE_W-1:0] gs, logic [POS_W-1:0] p, bit q);
      queue_req_type it;
      it.func  = f;
      it.ident = id;
      it.gsize = gs;
      it.pos   = p;
      it.hold  = 1'b0;
      it.quiet = q;
      req_backlog.push_back(it);
      case (f)
         FUNC_PUSH:   if (gen_len < QDEPTH) gen_len++;
         FUNC_POP:    if (gen_len > 0) gen_len--;
         FUNC_REMOVE: if (int'(p) < gen_len) gen_len--;
         default: ;
      endcase
   endfunction

   function automatic void add_hold();
      queue_req_type it;
      it = '{func: FUNC_PUSH, ident: '0, gsize: '0, pos: '0, hold: 1'b1, quiet: 1'b0};
      req_backlog.push_back(it);
   endfunction

   // Stimulus, reset and end of run
   initial begin
      int       seg_left;
      int       mode;
      bit       seg_quiet;
      int       w;
      int       pw;
      func_type f;
      logic [POS_W-1:0] p;

      // empty queue: pop, peek and remove all refused
      add_req(FUNC_POP, '0, '0, '0, 1'b0);
      add_req(FUNC_PEEK, 31'h7FFF_FFFF, 8'hFF, 8'd0, 1'b0);
      add_req(FUNC_REMOVE, '0, '0, 8'd255, 1'b0);
      // fill to capacity, field extremes first
      for (int i = 0; i < QDEPTH; i++) begin
         if (i == 0)
            add_req(FUNC_PUSH, 31'h0, 8'h00, 8'hFF, 1'b0);
         else if (i == 1)
            add_req(FUNC_PUSH, 31'h7FFF_FFFF, 8'hFF, 8'h00, 1'b0);
         else
            add_req(FUNC_PUSH, IDENT_W'((i * 32'h0913_5A27) ^ 32'h2AAA_AAAA),
                    GSIZE_W'(i * 17), 8'h80, 1'b0);
      end
      // push on a full queue, last valid position and one past it
      add_req(FUNC_PUSH, 31'h2AAA_AAAA, 8'h55, '0, 1'b0);
      add_req(FUNC_PEEK, '0, '0, 8'd15, 1'b0);
      add_req(FUNC_PEEK, '0, '0, 8'd16, 1'b0);
      // removal from the middle and from the tail, then a head pop
      add_req(FUNC_REMOVE, '0, '0, 8'd7, 1'b0);
      add_req(FUNC_REMOVE, '0, '0, 8'd14, 1'b0);
      add_req(FUNC_POP, '0, '0, '0, 1'b0);
      add_hold();

      // random segments, each with its own traffic bias
      seg_left  = 0;
      mode      = 0;
      seg_quiet = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            seg_left  = $urandom_range(40, 120);
            mode      = $urandom_range(0, 2);
            seg_quiet = ($urandom_range(0, 3) == 0);
         end
         seg_left--;
         if (n == 600 || n == 1200)
            add_hold();
         w = $urandom_range(0, 99);
         case (mode)
            0:       f = (w < 60) ? FUNC_PUSH : (w < 75) ? FUNC_POP :
                         (w < 85) ? FUNC_PEEK : FUNC_REMOVE;
            1:       f = (w < 15) ? FUNC_PUSH : (w < 50) ? FUNC_POP :
                         (w < 65) ? FUNC_PEEK : FUNC_REMOVE;
            default: f = (w < 35) ? FUNC_PUSH : (w < 55) ? FUNC_POP :
                         (w < 80) ? FUNC_PEEK : FUNC_REMOVE;
         endcase
         // mostly a held position, sometimes the first one out of range, else any
         pw = $urandom_range(0, 9);
         if (pw < 8 && gen_len > 0)
            p = POS_W'($urandom_range(0, gen_len - 1));
         else if (pw == 8)
            p = POS_W'(gen_len);
         else
            p = POS_W'($urandom_range(0, 255));
         add_req(f, IDENT_W'($urandom), GSIZE_W'($urandom), p, seg_quiet);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (2 * QDEPTH + 8) @(posedge clock);
      if (mismatches == 0 && rsp_expected.size() == 0) begin
         $display("PASS fifo_wait_queue_indexed");
      end else begin
         $display("FAIL fifo_wait_queue_indexed");
      end
      $finish;
   end

   // Request driver: holds each transfer until taken, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // transfer still waiting for req_tready
      end else begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (req_backlog.size() != 0 && req_backlog[0].hold) begin
            req_tvalid <= 1'b0;
            if (rsp_expected.size() == 0)
               void'(req_backlog.pop_front());
         end else if (req_backlog.size() != 0) begin
            if (!req_backlog[0].quiet && req_backlog.size() > CALM_TAIL &&
                $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 13) - 1;
               req_tvalid <= 1'b0;
            end else begin
               drv_item = req_backlog.pop_front();
               if (req_backlog.size() < CALM_TAIL)
                  drv_item.quiet = 1'b1;
               req_tdata  <= {1'b0, drv_item.pos, drv_item.gsize, drv_item.ident};
               req_tuser  <= drv_item.func;
               req_tvalid <= 1'b1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result back-pressure in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet_now && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      queue_rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expected.size() == 0) begin
               $error("unexpected result transfer, tdata %h tuser %0d", rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               exp_rsp = rsp_expected.pop_front();
               if (rsp_tuser !== exp_rsp.status) begin
                  $error("status: expected %s actual %0d", exp_rsp.status.name(), rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[30:0] !== exp_rsp.ident) begin
                  $error("out_ident: expected %h actual %h", exp_rsp.ident, rsp_tdata[30:0]);
                  mismatches++;
               end
               if (rsp_tdata[38:31] !== exp_rsp.gsize) begin
                  $error("out_group_size: expected %h actual %h",
                         exp_rsp.gsize, rsp_tdata[38:31]);
                  mismatches++;
               end
               if (rsp_tdata[43:39] !== exp_rsp.length) begin
                  $error("length: expected %0d actual %0d", exp_rsp.length, rsp_tdata[43:39]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rsp_expected.push_back(apply_queue_op(drv_item));
            quiet_now = drv_item.quiet;
            req_taken = 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL fifo_wait_queue_indexed");
         $finish;
      end
   end

endmodule

// ===== files.f =====
hdl/fwqi_pkg.sv
hdl/fwqi_ram.sv
hdl/fifo_wait_queue_indexed.sv
tb/sv/tb.sv
